/* sv/ffd_pkg.sv */
// Package for the free-fall and impact fall detector.
// Holds the configuration register indexes, their reset values and the
// shared types. No dependencies.
`default_nettype none
package ffd_pkg;

    localparam int unsigned CntW   = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned LevelW = 32;
    localparam int unsigned MsW    = 16;
    localparam int unsigned ModeW  = 2;
    localparam int unsigned SqW    = 31;
    localparam int unsigned HitW   = 32;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned CfgW   = 32;
    localparam int unsigned InW    = 128;
    localparam int unsigned OutW   = 40;

    typedef enum logic [IdxW-1:0] {
        REG_FREEFALL_LEVEL = 3'd0,
        REG_IMPACT_LEVEL   = 3'd1,
        REG_ROTATION_LEVEL = 3'd2,
        REG_FREEFALL_MIN   = 3'd3,
        REG_CONFIRM_WINDOW = 3'd4,
        REG_COOLDOWN       = 3'd5,
        REG_HOLD           = 3'd6,
        REG_MODE           = 3'd7
    } t_reg_idx;

    localparam logic [ModeW-1:0] DET_NN_ONLY = 2'd0;
    localparam logic [ModeW-1:0] DET_RULE    = 2'd1;
    localparam logic [ModeW-1:0] DET_RULE_NN = 2'd2;

    localparam logic [LevelW-1:0] RST_FREEFALL_LEVEL = 32'd1772093;
    localparam logic [LevelW-1:0] RST_IMPACT_LEVEL   = 32'd26214400;
    localparam logic [LevelW-1:0] RST_ROTATION_LEVEL = 32'd16810000;
    localparam logic [MsW-1:0]    RST_FREEFALL_MIN   = 16'd80;
    localparam logic [MsW-1:0]    RST_CONFIRM_WINDOW = 16'd1500;
    localparam logic [MsW-1:0]    RST_COOLDOWN       = 16'd5000;
    localparam logic [MsW-1:0]    RST_HOLD           = 16'd3000;

    typedef struct packed {
        logic [LevelW-1:0] freefall_level_sq;
        logic [LevelW-1:0] impact_level_sq;
        logic [LevelW-1:0] rotation_level_sq;
        logic [MsW-1:0]    min_fall_ms;
        logic [MsW-1:0]    confirm_window_ms;
        logic [MsW-1:0]    cooldown_ms;
        logic [MsW-1:0]    hold_ms;
        logic [ModeW-1:0]  detector_mode;
    } t_cfg;

    // Threshold results for one sample.
    typedef struct packed {
        logic low_accel;
        logic impact;
        logic rotation;
    } t_flags;

endpackage
`default_nettype wire

/* sv/ffd_cfg.sv */
// Configuration register bank of the fall detector.
// Depends on ffd_pkg for register indexes, reset values and t_cfg.
`default_nettype none
module ffd_cfg (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [ffd_pkg::IdxW-1:0] i_cfg_index,
    input  wire logic [ffd_pkg::CfgW-1:0] i_cfg_data,
    output ffd_pkg::t_cfg                o_cfg
);
    import ffd_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freefall_level_sq <= RST_FREEFALL_LEVEL;
            r_cfg.impact_level_sq   <= RST_IMPACT_LEVEL;
            r_cfg.rotation_level_sq <= RST_ROTATION_LEVEL;
            r_cfg.min_fall_ms       <= RST_FREEFALL_MIN;
            r_cfg.confirm_window_ms <= RST_CONFIRM_WINDOW;
            r_cfg.cooldown_ms       <= RST_COOLDOWN;
            r_cfg.hold_ms           <= RST_HOLD;
            r_cfg.detector_mode     <= DET_NN_ONLY;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FREEFALL_LEVEL: r_cfg.freefall_level_sq <= i_cfg_data;
                REG_IMPACT_LEVEL:   r_cfg.impact_level_sq   <= i_cfg_data;
                REG_ROTATION_LEVEL: r_cfg.rotation_level_sq <= i_cfg_data;
                REG_FREEFALL_MIN:   r_cfg.min_fall_ms       <= i_cfg_data[MsW-1:0];
                REG_CONFIRM_WINDOW: r_cfg.confirm_window_ms <= i_cfg_data[MsW-1:0];
                REG_COOLDOWN:       r_cfg.cooldown_ms       <= i_cfg_data[MsW-1:0];
                REG_HOLD:           r_cfg.hold_ms           <= i_cfg_data[MsW-1:0];
                REG_MODE:           r_cfg.detector_mode     <= i_cfg_data[ModeW-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/ffd_mag.sv */
// Magnitude pipeline: input register, registered squares, then sums and
// threshold compares. Depends on ffd_pkg for widths, t_cfg and t_flags.
`default_nettype none
module ffd_mag (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [ffd_pkg::InW-1:0]  i_data,
    input  wire ffd_pkg::t_cfg            i_cfg,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output ffd_pkg::t_flags               o_flags,
    output logic [ffd_pkg::TimeW-1:0]     o_now
);
    import ffd_pkg::*;

    // Stage 1: captured sample.
    logic                    r_v1;
    logic signed [CntW-1:0]  r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [TimeW-1:0]        r_now1;
    // Stage 2: squares.
    logic                    r_v2;
    logic [SqW-1:0]          r_sq [6];
    logic [TimeW-1:0]        r_now2;
    // Stage 3: compare results.
    logic                    r_v3;
    t_flags                  r_flags;
    logic [TimeW-1:0]        r_now3;

    logic adv1, adv2, adv3;
    logic signed [31:0] p [6];
    logic [LevelW-1:0] acc_sum, rot_sum;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    assign p[0] = r_ax * r_ax;
    assign p[1] = r_ay * r_ay;
    assign p[2] = r_az * r_az;
    assign p[3] = r_gx * r_gx;
    assign p[4] = r_gy * r_gy;
    assign p[5] = r_gz * r_gz;

    // Each square is at most 2^30, so three of them fit in 32 bits.
    assign acc_sum = LevelW'(r_sq[0]) + LevelW'(r_sq[1]) + LevelW'(r_sq[2]);
    assign rot_sum = LevelW'(r_sq[3]) + LevelW'(r_sq[4]) + LevelW'(r_sq[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_ax   <= i_data[15:0];
            r_ay   <= i_data[31:16];
            r_az   <= i_data[47:32];
            r_gx   <= i_data[63:48];
            r_gy   <= i_data[79:64];
            r_gz   <= i_data[95:80];
            r_now1 <= i_data[127:96];
        end
        if (adv2 && r_v1) begin
            for (int k = 0; k < 6; k++) begin
                r_sq[k] <= p[k][SqW-1:0];
            end
            r_now2 <= r_now1;
        end
        if (adv3 && r_v2) begin
            r_flags.low_accel <= acc_sum <= i_cfg.freefall_level_sq;
            r_flags.impact    <= acc_sum >= i_cfg.impact_level_sq;
            r_flags.rotation  <= rot_sum >= i_cfg.rotation_level_sq;
            r_now3            <= r_now2;
        end
    end

    assign o_valid = r_v3;
    assign o_flags = r_flags;
    assign o_now   = r_now3;

endmodule
`default_nettype wire

/* sv/ffd_ctl.sv */
// Detection state and result register of the fall detector.
// Tracks free-fall, confirms falls, runs the alarm timers. Depends on ffd_pkg.
`default_nettype none
module ffd_ctl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire ffd_pkg::t_flags       i_flags,
    input  wire logic [ffd_pkg::TimeW-1:0] i_now,
    input  wire ffd_pkg::t_cfg         i_cfg,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [ffd_pkg::OutW-1:0]   o_data
);
    import ffd_pkg::*;

    logic             r_ff, n_ff;
    logic [TimeW-1:0] r_ff_start, n_ff_start;
    logic             r_alarm, n_alarm;
    logic [TimeW-1:0] r_alarm_start, n_alarm_start;
    logic [TimeW-1:0] r_last_alarm, n_last_alarm;
    logic [HitW-1:0]  r_hits, n_hits;
    logic             n_hit, n_started;

    logic             r_out_valid;
    logic             r_hit, r_started, r_alarm_o, r_ff_o;
    logic [HitW-1:0]  r_hits_o;

    logic             take;
    logic             mode_alarm;
    logic [TimeW-1:0] dur;
    logic             long_enough, in_window;

    assign o_ready    = !r_out_valid || i_ready;
    assign take       = i_valid && o_ready;
    assign mode_alarm = (i_cfg.detector_mode == DET_RULE) ||
                        (i_cfg.detector_mode == DET_RULE_NN);

    always_comb begin
        n_alarm       = r_alarm;
        n_alarm_start = r_alarm_start;
        n_last_alarm  = r_last_alarm;
        n_ff          = r_ff;
        n_ff_start    = r_ff_start;
        n_hits        = r_hits;
        n_hit         = 1'b0;
        n_started     = 1'b0;

        if (r_alarm && (i_now - r_alarm_start) >= TimeW'(i_cfg.hold_ms)) begin
            n_alarm = 1'b0;
        end

        if (!r_ff && i_flags.low_accel) begin
            n_ff       = 1'b1;
            n_ff_start = i_now;
        end

        dur         = i_now - n_ff_start;
        long_enough = dur >= TimeW'(i_cfg.min_fall_ms);
        in_window   = dur <= TimeW'(i_cfg.confirm_window_ms);

        if (n_ff) begin
            if (long_enough && in_window && (i_flags.impact || i_flags.rotation)) begin
                n_hit = 1'b1;
                if (r_hits != {HitW{1'b1}}) begin
                    n_hits = r_hits + 1'b1;
                end
                if (mode_alarm && !n_alarm &&
                    (i_now - r_last_alarm) >= TimeW'(i_cfg.cooldown_ms)) begin
                    n_alarm       = 1'b1;
                    n_alarm_start = i_now;
                    n_last_alarm  = i_now;
                    n_started     = 1'b1;
                end
                n_ff = 1'b0;
            end else if (!in_window) begin
                n_ff = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff          <= 1'b0;
            r_ff_start    <= '0;
            r_alarm       <= 1'b0;
            r_alarm_start <= '0;
            r_last_alarm  <= '0;
            r_hits        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (take) begin
                r_ff          <= n_ff;
                r_ff_start    <= n_ff_start;
                r_alarm       <= n_alarm;
                r_alarm_start <= n_alarm_start;
                r_last_alarm  <= n_last_alarm;
                r_hits        <= n_hits;
            end
            if (o_ready) r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hit     <= n_hit;
            r_started <= n_started;
            r_alarm_o <= n_alarm;
            r_ff_o    <= n_ff;
            r_hits_o  <= n_hits;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {4'b0, r_hits_o, r_ff_o, r_alarm_o, r_started, r_hit};

    // An alarm only starts from a confirmed fall and leaves the alarm on.
    a_start_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_started || (r_hit && r_alarm_o)))
        else $error("alarm started without a confirmed fall");

    // A confirmed fall always ends free-fall tracking.
    a_hit_ends_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_hit || !r_ff_o))
        else $error("free-fall still tracked after a hit");

    // The hit counter moves by at most one per sample, and only on a hit.
    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_hits == $past(r_hits)) ||
                 (r_hits == $past(r_hits) + 1'b1 && r_hit))
        else $error("hit counter stepped wrongly");

    // Without rule mode no alarm is ever started.
    a_mode_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !mode_alarm) |=> !r_started)
        else $error("alarm started outside rule mode");

endmodule
`default_nettype wire

/* sv/freefall_impact_fall_detector.sv */
// Top level of the free-fall and impact fall detector.
// Instantiates ffd_cfg, ffd_mag and ffd_ctl; depends on ffd_pkg.
`default_nettype none
// One six-axis sample enters per transfer and yields exactly one result.
// The block accepts a new sample every clock cycle; a sample's result is
// presented once it has passed the input register, the squaring multipliers,
// the sum-and-compare stage and the state and result register. Back-pressure
// on the result side ripples back through the stage valids, so bubbles are
// squeezed out before input is stalled.
// Configuration writes are always ready and should be made while no sample is
// in flight.
module freefall_impact_fall_detector (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 each), now_ms (32)
    input  wire logic [ffd_pkg::InW-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // fall_hit, alarm_started, alarm_on, in_freefall (1 each), hit_count (32),
    // then 4 zero bits
    output logic [ffd_pkg::OutW-1:0]      o_m_tdata,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [ffd_pkg::IdxW-1:0] i_cfg_index,
    input  wire logic [ffd_pkg::CfgW-1:0] i_cfg_data
);
    import ffd_pkg::*;

    t_cfg             cfg;
    t_flags           flags;
    logic             mag_valid, ctl_ready;
    logic [TimeW-1:0] mag_now;

    ffd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ffd_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_cfg   (cfg),
        .o_valid (mag_valid),
        .i_ready (ctl_ready),
        .o_flags (flags),
        .o_now   (mag_now)
    );

    ffd_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mag_valid),
        .o_ready (ctl_ready),
        .i_flags (flags),
        .i_now   (mag_now),
        .i_cfg   (cfg),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule
`default_nettype wire
